>>> rtl/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg - shared types and constants for the character-LCD write sequencer
// Request codes, register map, reset values, bus constants and the
// configuration struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdws_pkg;

	// Request codes
	localparam int unsigned CMD_W = 3;
	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_INIT  = 3'd0;
	localparam cmd_t CMD_BYTE  = 3'd1;
	localparam cmd_t CMD_DATA  = 3'd2;
	localparam cmd_t CMD_CLEAR = 3'd3;
	localparam cmd_t CMD_MOVE  = 3'd4;

	// Field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PRE_W  = 7;
	localparam int unsigned POST_W = 5;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [PRE_W-1:0]  pre_t;
	typedef logic [POST_W-1:0] post_t;

	// Register map: register i at byte address 4*i
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned DATA_W    = 32;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_BUS_MODE   = 3'd0;
	localparam reg_idx_t REG_EIGHT_CODE = 3'd1;
	localparam reg_idx_t REG_FOUR_CODE  = 3'd2;
	localparam reg_idx_t REG_HOME_CODE  = 3'd3;
	localparam reg_idx_t REG_DISP_CODE  = 3'd4;
	localparam reg_idx_t REG_CLEAR_CODE = 3'd5;

	// Reset values
	localparam byte_t RST_EIGHT_CODE = 8'd56;
	localparam byte_t RST_FOUR_CODE  = 8'd40;
	localparam byte_t RST_HOME_CODE  = 8'd2;
	localparam byte_t RST_DISP_CODE  = 8'd14;
	localparam byte_t RST_CLEAR_CODE = 8'd1;

	// Cursor addressing
	localparam byte_t LINE1_BASE = 8'h80;
	localparam byte_t LINE2_BASE = 8'hC0;
	localparam byte_t COL_MAX    = 8'd16;
	localparam byte_t ROW_ONE    = 8'd1;
	localparam byte_t ROW_TWO    = 8'd2;
	localparam byte_t NIB_MASK   = 8'hF0;

	// Waits in milliseconds
	localparam pre_t  PRE_INIT_MS    = 7'd100;
	localparam post_t POST_STEP_MS   = 5'd1;
	localparam post_t POST_END8_MS   = 5'd10;
	localparam post_t POST_END4_MS   = 5'd20;

	typedef struct packed {
		logic  four_bit;
		byte_t eight_code;
		byte_t four_code;
		byte_t home_code;
		byte_t disp_code;
		byte_t clear_code;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/lcdws_if.sv
// ----------------------------------------------------------------------------
// lcdws_if - request and bus-event channels
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdws_req_if;
	import lcdws_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  cmd;
	byte_t value;
	byte_t row;
	byte_t column;

	modport source (output valid, output cmd, output value, output row, output column,
		input ready);
	modport sink (input valid, input cmd, input value, input row, input column,
		output ready);
endinterface

interface lcdws_evt_if;
	import lcdws_pkg::*;

	logic  valid;
	logic  ready;
	logic  reg_select;
	byte_t bus_value;
	pre_t  pre_wait_ms;
	post_t post_wait_ms;
	logic  last;

	modport source (output valid, output reg_select, output bus_value,
		output pre_wait_ms, output post_wait_ms, output last, input ready);
	modport sink (input valid, input reg_select, input bus_value,
		input pre_wait_ms, input post_wait_ms, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/lcdws_regs.sv
// ----------------------------------------------------------------------------
// lcdws_regs - configuration register file
// APB-style write and read of the bus mode and the init command bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_regs (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [lcdws_pkg::ADDR_W-1:0] paddr,
	input  wire logic [lcdws_pkg::DATA_W-1:0] pwdata,
	output logic      [lcdws_pkg::DATA_W-1:0] prdata,
	output logic                          pready,
	output lcdws_pkg::cfg_t               cfg
);
	import lcdws_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit   <= 1'b0;
			cfg_q.eight_code <= RST_EIGHT_CODE;
			cfg_q.four_code  <= RST_FOUR_CODE;
			cfg_q.home_code  <= RST_HOME_CODE;
			cfg_q.disp_code  <= RST_DISP_CODE;
			cfg_q.clear_code <= RST_CLEAR_CODE;
		end else if (wr_en) begin
			case (idx)
				REG_BUS_MODE:   cfg_q.four_bit   <= pwdata[0];
				REG_EIGHT_CODE: cfg_q.eight_code <= pwdata[BYTE_W-1:0];
				REG_FOUR_CODE:  cfg_q.four_code  <= pwdata[BYTE_W-1:0];
				REG_HOME_CODE:  cfg_q.home_code  <= pwdata[BYTE_W-1:0];
				REG_DISP_CODE:  cfg_q.disp_code  <= pwdata[BYTE_W-1:0];
				REG_CLEAR_CODE: cfg_q.clear_code <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BUS_MODE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.four_bit};
			REG_EIGHT_CODE: prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.eight_code};
			REG_FOUR_CODE:  prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.four_code};
			REG_HOME_CODE:  prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.home_code};
			REG_DISP_CODE:  prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.disp_code};
			REG_CLEAR_CODE: prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.clear_code};
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/lcdws_expand.sv
// ----------------------------------------------------------------------------
// lcdws_expand - request register, event builder and output register
// Holds one decoded request and walks its pulses, one word per cycle while the bus side is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_expand (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lcdws_pkg::cfg_t cfg,
	lcdws_req_if.sink            req,
	lcdws_evt_if.source          evt
);
	import lcdws_pkg::*;

	// request stage
	logic       req_vld_s1;
	logic       rs_s1;
	logic       init_s1;
	byte_t      byte_s1;
	logic [2:0] idx_q;

	// output stage
	logic  evt_vld_s2;
	logic  rs_s2;
	byte_t bus_s2;
	pre_t  pre_s2;
	post_t post_s2;
	logic  last_s2;

	// accept-side decode
	logic       acc;
	logic       keep;
	logic       col_ok;
	logic [3:0] col_m1;
	byte_t      addr;
	byte_t      in_byte;
	logic       in_rs;
	logic       in_init;

	// event builder
	logic [1:0] b;
	logic       lo_nib;
	logic       byte_end;
	byte_t      init_byte;
	byte_t      cur_byte;
	byte_t      ev_bus;
	pre_t       ev_pre;
	post_t      ev_post;
	logic       ev_last;
	logic       emit;

	assign acc    = req.valid && req.ready;
	assign col_ok = (req.column >= 8'd1) && (req.column <= COL_MAX);
	assign col_m1 = req.column[3:0] - 4'd1;

	always_comb begin
		if (col_ok && req.row == ROW_ONE) begin
			addr = LINE1_BASE | {4'h0, col_m1};
		end else if (col_ok && req.row == ROW_TWO) begin
			addr = LINE2_BASE | {4'h0, col_m1};
		end else begin
			addr = LINE1_BASE;
		end
	end

	always_comb begin
		keep    = 1'b1;
		in_rs   = 1'b0;
		in_init = 1'b0;
		in_byte = req.value;
		case (req.cmd)
			CMD_INIT:  in_init = 1'b1;
			CMD_BYTE:  in_byte = req.value;
			CMD_DATA:  in_rs   = 1'b1;
			CMD_CLEAR: in_byte = cfg.clear_code;
			CMD_MOVE:  in_byte = addr;
			default:   keep    = 1'b0;
		endcase
	end

	// pulse index -> byte index and nibble
	assign b        = cfg.four_bit ? idx_q[2:1] : idx_q[1:0];
	assign lo_nib   = cfg.four_bit && idx_q[0];
	assign byte_end = !cfg.four_bit || idx_q[0];

	always_comb begin
		case (b)
			2'd0:    init_byte = cfg.four_bit ? cfg.home_code : cfg.eight_code;
			2'd1:    init_byte = cfg.four_bit ? cfg.four_code : cfg.home_code;
			2'd2:    init_byte = cfg.disp_code;
			default: init_byte = cfg.clear_code;
		endcase
	end

	assign cur_byte = init_s1 ? init_byte : byte_s1;

	always_comb begin
		if (!cfg.four_bit) begin
			ev_bus = cur_byte;
		end else if (lo_nib) begin
			ev_bus = {cur_byte[3:0], 4'h0};
		end else begin
			ev_bus = cur_byte & NIB_MASK;
		end
	end

	assign ev_pre = (init_s1 && idx_q == 3'd0) ? PRE_INIT_MS : '0;

	always_comb begin
		if (!(init_s1 && byte_end)) begin
			ev_post = '0;
		end else if (b != 2'd3) begin
			ev_post = POST_STEP_MS;
		end else begin
			ev_post = cfg.four_bit ? POST_END4_MS : POST_END8_MS;
		end
	end

	assign ev_last = byte_end && (!init_s1 || b == 2'd3);

	assign emit      = req_vld_s1 && (!evt_vld_s2 || evt.ready);
	assign req.ready = !req_vld_s1 || (emit && ev_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
			idx_q      <= '0;
		end else if (acc) begin
			req_vld_s1 <= keep;
			idx_q      <= '0;
		end else if (emit && ev_last) begin
			req_vld_s1 <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rs_s1   <= in_rs;
			init_s1 <= in_init;
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_vld_s2 <= 1'b0;
		end else if (emit) begin
			evt_vld_s2 <= 1'b1;
		end else if (evt.ready) begin
			evt_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rs_s2   <= rs_s1;
			bus_s2  <= ev_bus;
			pre_s2  <= ev_pre;
			post_s2 <= ev_post;
			last_s2 <= ev_last;
		end
	end

	assign evt.valid        = evt_vld_s2;
	assign evt.reg_select   = rs_s2;
	assign evt.bus_value    = bus_s2;
	assign evt.pre_wait_ms  = pre_s2;
	assign evt.post_wait_ms = post_s2;
	assign evt.last         = last_s2;

endmodule

`default_nettype wire

>>> rtl/char_lcd_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_core - character-LCD write sequencer
// Turns LCD requests (init, command, data, clear, move cursor) into a run of
// bus write words, one word per enable pulse.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          carries
//   -------  ---  -----------------  ---------------------------------------
//   req      in   valid/ready        cmd, value, row, column
//   evt      out  valid/ready        reg_select, bus_value, pre/post wait, last
//   apb      in   psel/penable/pwr   bus mode and init command bytes
//
// One request yields 1 word (byte, eight-bit bus), 2 words (byte, four-bit
// bus), 4 words (init, eight-bit) or 8 words (init, four-bit); the request
// register emits one word per cycle into the output register while that
// register is empty or its word is taken. Requests with codes 5 to 7 are
// taken and give nothing. A new request is taken in the cycle its
// predecessor's last word moves to the output register. Reset clears both
// valid flags and restores the register defaults; a stalled output holds its
// word and the request register waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_write_sequencer_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	lcdws_req_if.sink                         req,
	lcdws_evt_if.source                       evt,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lcdws_pkg::ADDR_W-1:0] paddr,
	input  wire logic [lcdws_pkg::DATA_W-1:0] pwdata,
	output logic      [lcdws_pkg::DATA_W-1:0] prdata,
	output logic                              pready
);
	import lcdws_pkg::*;

	// live configuration; to be written only while the sequencer is idle, which the block does not enforce
	cfg_t cfg;

	lcdws_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// hold the request, walk its pulses and register each word for the bus side
	lcdws_expand u_expand (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.evt    (evt)
	);

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the character-LCD write sequencer
// Feeds directed and random LCD requests in bursts while the bus-word side
// stalls on a shifting pattern. It checks every bus word against a
// behavioural expansion of each accepted request, in both bus modes and at
// several register settings.
// ----------------------------------------------------------------------------
module testbench;
	import lcdws_pkg::*;

	localparam int unsigned HALF_PERIOD     = 6;
	localparam int unsigned RESET_CYCLES    = 11;
	localparam int unsigned DRAIN_CYCLES    = 16;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT     = 1500000;
	localparam int unsigned RANDOM_PHASES   = 6;
	localparam int unsigned PHASE_ITEMS     = 40;
	localparam int unsigned PRINT_LIMIT     = 40;

	// Request codes 5..7 are not decoded by the block
	localparam cmd_t CMD_UNKNOWN_LO = 3'd5;
	localparam cmd_t CMD_UNKNOWN_MID = 3'd6;
	localparam cmd_t CMD_UNKNOWN_HI = 3'd7;

	localparam logic  RS_COMMAND = 1'b0;
	localparam logic  RS_DATA    = 1'b1;
	localparam pre_t  NO_PRE     = '0;
	localparam post_t NO_POST    = '0;

	typedef struct packed {
		cmd_t  cmd;
		byte_t value;
		byte_t row;
		byte_t column;
	} lcd_request_t;

	typedef struct packed {
		logic  reg_select;
		byte_t bus_value;
		pre_t  pre_wait_ms;
		post_t post_wait_ms;
		logic  last;
	} bus_word_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	lcdws_req_if req_ch();
	lcdws_evt_if evt_ch();

	char_lcd_write_sequencer_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.evt     (evt_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Own copy of the register file, updated as each write goes out
	cfg_t         lcd_settings;
	lcd_request_t request_queue[$];
	bus_word_t    words_due[$];

	bit          req_taken      = 1'b0;
	bit          sender_steady  = 1'b0;
	bit          hold_off_start = 1'b0;
	int unsigned hold_off_left  = 0;
	int unsigned burst_left     = 0;
	int unsigned gap_left       = 0;
	int unsigned stall_span     = 0;
	logic [15:0] stall_pattern  = '1;

	int unsigned mismatches        = 0;
	int unsigned words_checked     = 0;
	int unsigned requests_taken    = 0;
	int unsigned four_bit_requests = 0;
	int unsigned cycle_count       = 0;
	int unsigned cmd_seen[8]       = '{default: 0};

	always #(HALF_PERIOD) clk = ~clk;

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("cycle %0d: %s mismatch, got 0x%0h expected 0x%0h",
				cycle_count, what, got, want);
	endtask

	// One byte on the bus: a whole word on the eight-bit bus, or the high and
	// then the low nibble on bits 7..4 of the four-bit bus. Only the first
	// pulse carries the pre-wait, only the second the post-wait and last.
	function automatic void push_lcd_byte(logic rs, byte_t code, pre_t pre, post_t post,
		logic fin);
		bus_word_t w;
		w.reg_select = rs;
		w.pre_wait_ms = pre;
		if (lcd_settings.four_bit) begin
			w.bus_value    = code & NIB_MASK;
			w.post_wait_ms = NO_POST;
			w.last         = 1'b0;
			words_due.push_back(w);
			w.bus_value    = {code[3:0], 4'h0};
			w.pre_wait_ms  = NO_PRE;
		end else begin
			w.bus_value    = code;
		end
		w.post_wait_ms = post;
		w.last         = fin;
		words_due.push_back(w);
	endfunction

	function automatic void expand_request(lcd_request_t rq);
		byte_t cursor;
		case (rq.cmd)
			CMD_INIT: begin
				if (lcd_settings.four_bit) begin
					push_lcd_byte(RS_COMMAND, lcd_settings.home_code, PRE_INIT_MS,
						POST_STEP_MS, 1'b0);
					push_lcd_byte(RS_COMMAND, lcd_settings.four_code, NO_PRE,
						POST_STEP_MS, 1'b0);
					push_lcd_byte(RS_COMMAND, lcd_settings.disp_code, NO_PRE,
						POST_STEP_MS, 1'b0);
					push_lcd_byte(RS_COMMAND, lcd_settings.clear_code, NO_PRE,
						POST_END4_MS, 1'b1);
				end else begin
					push_lcd_byte(RS_COMMAND, lcd_settings.eight_code, PRE_INIT_MS,
						POST_STEP_MS, 1'b0);
					push_lcd_byte(RS_COMMAND, lcd_settings.home_code, NO_PRE,
						POST_STEP_MS, 1'b0);
					push_lcd_byte(RS_COMMAND, lcd_settings.disp_code, NO_PRE,
						POST_STEP_MS, 1'b0);
					push_lcd_byte(RS_COMMAND, lcd_settings.clear_code, NO_PRE,
						POST_END8_MS, 1'b1);
				end
			end
			CMD_BYTE:  push_lcd_byte(RS_COMMAND, rq.value, NO_PRE, NO_POST, 1'b1);
			CMD_DATA:  push_lcd_byte(RS_DATA, rq.value, NO_PRE, NO_POST, 1'b1);
			CMD_CLEAR: push_lcd_byte(RS_COMMAND, lcd_settings.clear_code, NO_PRE, NO_POST,
				1'b1);
			CMD_MOVE: begin
				// anything off the 2x16 screen falls back to the home address
				cursor = LINE1_BASE;
				if (rq.column >= 8'd1 && rq.column <= COL_MAX) begin
					if (rq.row == ROW_ONE)
						cursor = LINE1_BASE + rq.column - 8'd1;
					else if (rq.row == ROW_TWO)
						cursor = LINE2_BASE + rq.column - 8'd1;
				end
				push_lcd_byte(RS_COMMAND, cursor, NO_PRE, NO_POST, 1'b1);
			end
			default: ; // unknown requests give no word at all
		endcase
	endfunction

	function automatic lcd_request_t make_request(cmd_t cmd, byte_t value, byte_t row,
		byte_t column);
		lcd_request_t rq;
		rq.cmd    = cmd;
		rq.value  = value;
		rq.row    = row;
		rq.column = column;
		return rq;
	endfunction

	// Random request; unused fields carry noise so every bit toggles
	function automatic lcd_request_t random_request();
		lcd_request_t rq;
		int unsigned  pick;
		pick = $urandom_range(0, 99);
		rq = make_request(CMD_DATA, byte_t'($urandom), byte_t'($urandom),
			byte_t'($urandom));
		if (pick < 8)
			rq.cmd = CMD_INIT;
		else if (pick < 30)
			rq.cmd = CMD_BYTE;
		else if (pick < 60)
			rq.cmd = CMD_DATA;
		else if (pick < 68)
			rq.cmd = CMD_CLEAR;
		else if (pick < 92) begin
			rq.cmd = CMD_MOVE;
			if ($urandom_range(0, 3) != 0) begin
				rq.row    = byte_t'($urandom_range(ROW_ONE, ROW_TWO));
				rq.column = byte_t'($urandom_range(1, COL_MAX));
			end
		end else begin
			rq.cmd = cmd_t'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
		end
		return rq;
	endfunction

	// Register access: setup cycle, then access cycle until pready
	task automatic apb_access(reg_idx_t idx, logic wr, byte_t data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(data);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (!wr && prdata !== DATA_W'(data))
			report_mismatch("register readback", prdata, 32'(data));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_register(reg_idx_t idx, byte_t data);
		byte_t held;
		held = data;
		case (idx)
			REG_BUS_MODE: begin
				held = {7'd0, data[0]};
				lcd_settings.four_bit = data[0];
			end
			REG_EIGHT_CODE: lcd_settings.eight_code = data;
			REG_FOUR_CODE:  lcd_settings.four_code  = data;
			REG_HOME_CODE:  lcd_settings.home_code  = data;
			REG_DISP_CODE:  lcd_settings.disp_code  = data;
			REG_CLEAR_CODE: lcd_settings.clear_code = data;
			default: ;
		endcase
		apb_access(idx, 1'b1, held);
		apb_access(idx, 1'b0, held);
	endtask

	task automatic write_all_registers(logic four_bit, byte_t e, byte_t f, byte_t h,
		byte_t d, byte_t c);
		write_register(REG_BUS_MODE, {7'd0, four_bit});
		write_register(REG_EIGHT_CODE, e);
		write_register(REG_FOUR_CODE, f);
		write_register(REG_HOME_CODE, h);
		write_register(REG_DISP_CODE, d);
		write_register(REG_CLEAR_CODE, c);
	endtask

	// Hold until every queued request is taken and every word seen, then let
	// an ignored request still in the block run out
	task automatic wait_until_drained();
		while (request_queue.size() != 0 || words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Record each accepted request word and expand it into its bus words.
	// The first bus word of a request passes the request register and the output
	// register before it can leave, so the monitor never races this push.
	always @(posedge clk) begin : request_tracker
		lcd_request_t rq;
		if (arst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
			rq = make_request(req_ch.cmd, req_ch.value, req_ch.row, req_ch.column);
			void'(request_queue.pop_front());
			expand_request(rq);
			cmd_seen[rq.cmd]++;
			if (lcd_settings.four_bit)
				four_bit_requests++;
			requests_taken++;
			req_taken = 1'b1;
		end
	end

	// Request driver: hold a pending word until taken, otherwise advance
	// through bursts and gaps; payload carries noise while valid is low.
	always @(negedge clk) begin : request_driver
		if (!(req_ch.valid && !req_taken)) begin
			req_taken = 1'b0;
			if (gap_left != 0 || request_queue.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				req_ch.valid  <= 1'b0;
				req_ch.cmd    <= cmd_t'($urandom);
				req_ch.value  <= byte_t'($urandom);
				req_ch.row    <= byte_t'($urandom);
				req_ch.column <= byte_t'($urandom);
			end else begin
				req_ch.valid  <= 1'b1;
				req_ch.cmd    <= request_queue[0].cmd;
				req_ch.value  <= request_queue[0].value;
				req_ch.row    <= request_queue[0].row;
				req_ch.column <= request_queue[0].column;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					if (sender_steady || $urandom_range(0, 3) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, 6);
				end
			end
		end
	end

	// Receiver: rotate a stall pattern, pick a fresh one now and then (all
	// ones gives a stretch without stalls); drop ready during a hold-off.
	always @(negedge clk) begin : word_receiver
		if (stall_span == 0) begin
			stall_span = $urandom_range(16, 80);
			case ($urandom_range(0, 3))
				0:       stall_pattern = '1;
				1:       stall_pattern = 16'($urandom);
				2:       stall_pattern = 16'($urandom | $urandom);
				default: stall_pattern = 16'($urandom & $urandom);
			endcase
		end
		stall_span--;
		stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
		evt_ch.ready <= (hold_off_left == 0) && stall_pattern[0];
	end

	// Long hold-off of the receiver, counted here once requested
	always @(posedge clk) begin : hold_off_counter
		if (hold_off_start) begin
			hold_off_left  = HOLD_OFF_CYCLES;
			hold_off_start = 1'b0;
		end else if (hold_off_left != 0) begin
			hold_off_left--;
		end
	end

	// Compare each bus word with the oldest one due
	always @(posedge clk) begin : word_monitor
		bus_word_t want;
		if (arst_n && evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) begin
			words_checked++;
			if (words_due.size() == 0) begin
				report_mismatch("unexpected word, bus_value", 32'(evt_ch.bus_value), 0);
			end else begin
				want = words_due.pop_front();
				if (evt_ch.reg_select !== want.reg_select)
					report_mismatch("reg_select", 32'(evt_ch.reg_select),
						32'(want.reg_select));
				if (evt_ch.bus_value !== want.bus_value)
					report_mismatch("bus_value", 32'(evt_ch.bus_value),
						32'(want.bus_value));
				if (evt_ch.pre_wait_ms !== want.pre_wait_ms)
					report_mismatch("pre_wait_ms", 32'(evt_ch.pre_wait_ms),
						32'(want.pre_wait_ms));
				if (evt_ch.post_wait_ms !== want.post_wait_ms)
					report_mismatch("post_wait_ms", 32'(evt_ch.post_wait_ms),
						32'(want.post_wait_ms));
				if (evt_ch.last !== want.last)
					report_mismatch("last", 32'(evt_ch.last), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped at the cycle limit with %0d words still due",
				words_due.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned added;
		int unsigned run;

		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		req_ch.valid  = 1'b0;
		req_ch.cmd    = CMD_INIT;
		req_ch.value  = '0;
		req_ch.row    = '0;
		req_ch.column = '0;
		evt_ch.ready  = 1'b0;

		lcd_settings.four_bit   = 1'b0;
		lcd_settings.eight_code = RST_EIGHT_CODE;
		lcd_settings.four_code  = RST_FOUR_CODE;
		lcd_settings.home_code  = RST_HOME_CODE;
		lcd_settings.disp_code  = RST_DISP_CODE;
		lcd_settings.clear_code = RST_CLEAR_CODE;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed, eight-bit bus at reset settings: byte extremes, every
		// request, cursor on both rows and at both ends, cursor off the
		// screen on each side, and two of the ignored codes
		request_queue.push_back(make_request(CMD_INIT, 8'h00, 8'h00, 8'h00));
		request_queue.push_back(make_request(CMD_BYTE, 8'h00, 8'h00, 8'h00));
		request_queue.push_back(make_request(CMD_BYTE, 8'hFF, 8'hFF, 8'hFF));
		request_queue.push_back(make_request(CMD_DATA, 8'h00, 8'h00, 8'h00));
		request_queue.push_back(make_request(CMD_DATA, 8'hFF, 8'hFF, 8'hFF));
		request_queue.push_back(make_request(CMD_CLEAR, 8'h3C, 8'h00, 8'h00));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, ROW_ONE, 8'd1));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, ROW_ONE, COL_MAX));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, ROW_TWO, 8'd1));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, ROW_TWO, COL_MAX));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, 8'd0, 8'd5));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, 8'd3, 8'd5));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, ROW_ONE, 8'd0));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, ROW_TWO, 8'd17));
		request_queue.push_back(make_request(CMD_MOVE, 8'hFF, 8'hFF, 8'hFF));
		request_queue.push_back(make_request(CMD_UNKNOWN_LO, 8'hFF, ROW_ONE, 8'd1));
		request_queue.push_back(make_request(CMD_UNKNOWN_HI, 8'h00, ROW_TWO, 8'd2));
		wait_until_drained();

		// Directed, four-bit bus: nibble split on every request kind
		write_register(REG_BUS_MODE, 8'd1);
		request_queue.push_back(make_request(CMD_INIT, 8'h00, 8'h00, 8'h00));
		request_queue.push_back(make_request(CMD_BYTE, 8'hA5, 8'h00, 8'h00));
		request_queue.push_back(make_request(CMD_DATA, 8'h5A, 8'h00, 8'h00));
		request_queue.push_back(make_request(CMD_CLEAR, 8'h00, 8'h00, 8'h00));
		request_queue.push_back(make_request(CMD_MOVE, 8'h00, ROW_TWO, COL_MAX));
		request_queue.push_back(make_request(CMD_UNKNOWN_MID, 8'hC3, 8'h00, 8'h00));
		wait_until_drained();

		// Random phases, each at its own register setting: all-zero and
		// all-ones codes first, then random codes; one phase holds the
		// receiver off while the sender keeps offering
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: write_all_registers(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				1: write_all_registers(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				2: write_all_registers(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				default: write_all_registers(ph[0], byte_t'($urandom), byte_t'($urandom),
					byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
			endcase
			sender_steady = (ph == 3) || ($urandom_range(0, 2) == 0);
			added = 0;
			while (added < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					// a string: place the cursor, then a run of characters
					request_queue.push_back(make_request(CMD_MOVE, byte_t'($urandom),
						byte_t'($urandom_range(ROW_ONE, ROW_TWO)),
						byte_t'($urandom_range(1, COL_MAX))));
					run = $urandom_range(3, 10);
					repeat (run)
						request_queue.push_back(make_request(CMD_DATA, byte_t'($urandom),
							byte_t'($urandom), byte_t'($urandom)));
					added += run + 1;
				end else begin
					request_queue.push_back(random_request());
					added++;
				end
			end
			if (ph == 3)
				hold_off_start = 1'b1;
			wait_until_drained();
		end

		$display("covered %0d requests: %0d init, %0d command, %0d data, %0d clear, %0d cursor,",
			requests_taken, cmd_seen[CMD_INIT], cmd_seen[CMD_BYTE], cmd_seen[CMD_DATA],
			cmd_seen[CMD_CLEAR], cmd_seen[CMD_MOVE]);
		$display("%0d ignored, %0d on the four-bit bus; %0d bus words checked, %0d mismatches",
			cmd_seen[CMD_UNKNOWN_LO] + cmd_seen[CMD_UNKNOWN_MID] + cmd_seen[CMD_UNKNOWN_HI],
			four_bit_requests, words_checked, mismatches);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
